// ===== rtl/core/md5_pkg.sv =====
// Shared types, constants and table functions for the MD5 digest block.
`default_nettype none
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [3:0]  LEN_LO_IDX = 4'd14;
  localparam logic [3:0]  LEN_HI_IDX = 4'd15;
  localparam logic [3:0]  LAST_ZERO_IDX = 4'd13;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
  } digest_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  typedef enum logic [3:0] {
    ST_ACCEPT,
    ST_LOAD,
    ST_STEP,
    ST_ADD,
    ST_PAD,
    ST_ZERO,
    ST_LEN_LO,
    ST_LEN_HI
  } state_t;

  typedef enum logic [1:0] {
    AFT_ACCEPT,
    AFT_PAD,
    AFT_ZERO,
    AFT_OUT
  } after_t;

  function automatic logic [3:0] msg_index(input logic [5:0] k);
    logic [3:0] p;
    p = k[3:0];
    case (k[5:4])
      2'd0: msg_index = p;
      2'd1: msg_index = 4'((p << 2) + p + 4'd1);
      2'd2: msg_index = 4'((p << 1) + p + 4'd5);
      default: msg_index = 4'((p << 3) - p);
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] k);
    case ({k[5:4], k[1:0]})
      4'h0: rot_amount = 5'd7;
      4'h1: rot_amount = 5'd12;
      4'h2: rot_amount = 5'd17;
      4'h3: rot_amount = 5'd22;
      4'h4: rot_amount = 5'd5;
      4'h5: rot_amount = 5'd9;
      4'h6: rot_amount = 5'd14;
      4'h7: rot_amount = 5'd20;
      4'h8: rot_amount = 5'd4;
      4'h9: rot_amount = 5'd11;
      4'ha: rot_amount = 5'd16;
      4'hb: rot_amount = 5'd23;
      4'hc: rot_amount = 5'd6;
      4'hd: rot_amount = 5'd10;
      4'he: rot_amount = 5'd15;
      default: rot_amount = 5'd21;
    endcase
  endfunction

  function automatic logic [31:0] sine_k(input logic [5:0] k);
    case (k)
      6'd0:  sine_k = 32'hd76aa478;  6'd1:  sine_k = 32'he8c7b756;
      6'd2:  sine_k = 32'h242070db;  6'd3:  sine_k = 32'hc1bdceee;
      6'd4:  sine_k = 32'hf57c0faf;  6'd5:  sine_k = 32'h4787c62a;
      6'd6:  sine_k = 32'ha8304613;  6'd7:  sine_k = 32'hfd469501;
      6'd8:  sine_k = 32'h698098d8;  6'd9:  sine_k = 32'h8b44f7af;
      6'd10: sine_k = 32'hffff5bb1;  6'd11: sine_k = 32'h895cd7be;
      6'd12: sine_k = 32'h6b901122;  6'd13: sine_k = 32'hfd987193;
      6'd14: sine_k = 32'ha679438e;  6'd15: sine_k = 32'h49b40821;
      6'd16: sine_k = 32'hf61e2562;  6'd17: sine_k = 32'hc040b340;
      6'd18: sine_k = 32'h265e5a51;  6'd19: sine_k = 32'he9b6c7aa;
      6'd20: sine_k = 32'hd62f105d;  6'd21: sine_k = 32'h02441453;
      6'd22: sine_k = 32'hd8a1e681;  6'd23: sine_k = 32'he7d3fbc8;
      6'd24: sine_k = 32'h21e1cde6;  6'd25: sine_k = 32'hc33707d6;
      6'd26: sine_k = 32'hf4d50d87;  6'd27: sine_k = 32'h455a14ed;
      6'd28: sine_k = 32'ha9e3e905;  6'd29: sine_k = 32'hfcefa3f8;
      6'd30: sine_k = 32'h676f02d9;  6'd31: sine_k = 32'h8d2a4c8a;
      6'd32: sine_k = 32'hfffa3942;  6'd33: sine_k = 32'h8771f681;
      6'd34: sine_k = 32'h6d9d6122;  6'd35: sine_k = 32'hfde5380c;
      6'd36: sine_k = 32'ha4beea44;  6'd37: sine_k = 32'h4bdecfa9;
      6'd38: sine_k = 32'hf6bb4b60;  6'd39: sine_k = 32'hbebfbc70;
      6'd40: sine_k = 32'h289b7ec6;  6'd41: sine_k = 32'heaa127fa;
      6'd42: sine_k = 32'hd4ef3085;  6'd43: sine_k = 32'h04881d05;
      6'd44: sine_k = 32'hd9d4d039;  6'd45: sine_k = 32'he6db99e5;
      6'd46: sine_k = 32'h1fa27cf8;  6'd47: sine_k = 32'hc4ac5665;
      6'd48: sine_k = 32'hf4292244;  6'd49: sine_k = 32'h432aff97;
      6'd50: sine_k = 32'hab9423a7;  6'd51: sine_k = 32'hfc93a039;
      6'd52: sine_k = 32'h655b59c3;  6'd53: sine_k = 32'h8f0ccc92;
      6'd54: sine_k = 32'hffeff47d;  6'd55: sine_k = 32'h85845dd1;
      6'd56: sine_k = 32'h6fa87e4f;  6'd57: sine_k = 32'hfe2ce6e0;
      6'd58: sine_k = 32'ha3014314;  6'd59: sine_k = 32'h4e0811a1;
      6'd60: sine_k = 32'hf7537e82;  6'd61: sine_k = 32'hbd3af235;
      6'd62: sine_k = 32'h2ad7d2bb;  default: sine_k = 32'heb86d391;
    endcase
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/md5_message_digest.sv =====
// MD5 digest top level: byte packing, block buffer RAM, padding and compression control.
// Each word is written into a 16-word block RAM. A full 64-byte block
// runs 64 steps, one per cycle, reading the message word from the RAM one step ahead,
// plus a load state to start and an add state to add into the chain. A last word adds
// the padding writes before each pass and one or two more block passes before the
// digest appears; the digest waits in an output register while the next message is
// taken in.
`default_nettype none
module md5_message_digest import md5_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         msg_valid,
  output logic              msg_ready,
  input  wire msg_item_t    msg,
  output logic              dig_valid,
  input  wire logic         dig_ready,
  output digest_item_t      dig
);
  logic [31:0] buf_mem [16];
  logic [31:0] rdata;

  state_t state, state_next;
  after_t after, after_next;
  abcd_t chain, work, step_out, sum;
  logic [5:0]  step, fill;
  logic [23:0] pend;
  logic [63:0] bit_len;
  logic [3:0]  wptr, wptr_next;

  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata;

  logic [2:0]  nbytes;
  logic [31:0] wmask;
  logic [55:0] comb;
  logic [2:0]  total;
  logic [6:0]  fill_sum;
  logic        accept, out_free, finish;
  logic [3:0]  pidx;

  md5_step u_step (.cur(work), .m(rdata), .k(step), .nxt(step_out));

  always_comb begin
    nbytes = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
    case (nbytes)
      3'd0: wmask = 32'h0;
      3'd1: wmask = 32'h000000ff;
      3'd2: wmask = 32'h0000ffff;
      3'd3: wmask = 32'h00ffffff;
      default: wmask = 32'hffffffff;
    endcase
    comb = {32'h0, pend} | ({24'h0, msg.message_word & wmask} << {fill[1:0], 3'b000});
    total = {1'b0, fill[1:0]} + nbytes;
    fill_sum = {1'b0, fill} + {4'h0, nbytes};
    pidx = fill[5:2];
    sum.a = chain.a + work.a;
    sum.b = chain.b + work.b;
    sum.c = chain.c + work.c;
    sum.d = chain.d + work.d;
    out_free = !dig_valid || dig_ready;
    accept = msg_valid && msg_ready;
  end

  always_comb begin
    state_next = state;
    after_next = after;
    wptr_next = wptr;
    msg_ready = 1'b0;
    we = 1'b0;
    waddr = pidx;
    wdata = comb[31:0];
    raddr = msg_index(6'(step + 6'd1));
    finish = 1'b0;
    case (state)
      ST_ACCEPT: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          we = total[2];
          if (fill_sum[6]) begin
            state_next = ST_LOAD;
            after_next = msg.last_word ? AFT_PAD : AFT_ACCEPT;
          end else if (msg.last_word) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        raddr = msg_index(6'd0);
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (step == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        case (after)
          AFT_ACCEPT: state_next = ST_ACCEPT;
          AFT_PAD: state_next = ST_PAD;
          AFT_ZERO: begin
            wptr_next = 4'd0;
            state_next = ST_ZERO;
          end
          default: begin
            if (out_free) begin
              finish = 1'b1;
              state_next = ST_ACCEPT;
            end
          end
        endcase
      end
      ST_PAD: begin
        we = 1'b1;
        wdata = {8'h0, pend} | ({24'h0, PAD_BYTE} << {fill[1:0], 3'b000});
        if (pidx == LEN_HI_IDX) begin
          after_next = AFT_ZERO;
          state_next = ST_LOAD;
        end else if (pidx == LAST_ZERO_IDX) begin
          state_next = ST_LEN_LO;
        end else begin
          wptr_next = pidx + 4'd1;
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        we = 1'b1;
        waddr = wptr;
        wdata = 32'h0;
        if (wptr == LEN_HI_IDX) begin
          after_next = AFT_ZERO;
          state_next = ST_LOAD;
        end else if (wptr == LAST_ZERO_IDX) begin
          state_next = ST_LEN_LO;
        end else begin
          wptr_next = wptr + 4'd1;
        end
      end
      ST_LEN_LO: begin
        we = 1'b1;
        waddr = LEN_LO_IDX;
        wdata = bit_len[31:0];
        state_next = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        we = 1'b1;
        waddr = LEN_HI_IDX;
        wdata = bit_len[63:32];
        after_next = AFT_OUT;
        state_next = ST_LOAD;
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) buf_mem[waddr] <= wdata;
    rdata <= buf_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
      after <= AFT_ACCEPT;
      wptr <= 4'd0;
      step <= 6'd0;
      fill <= 6'd0;
      pend <= 24'h0;
      bit_len <= 64'h0;
      chain <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
      work <= '0;
      dig_valid <= 1'b0;
    end else begin
      state <= state_next;
      after <= after_next;
      wptr <= wptr_next;
      if (finish) begin
        dig_valid <= 1'b1;
      end else if (dig_valid && dig_ready) begin
        dig_valid <= 1'b0;
      end
      if (accept) begin
        fill <= fill_sum[5:0];
        pend <= total[2] ? comb[55:32] : comb[23:0];
        bit_len <= bit_len + {58'h0, nbytes, 3'b000};
      end
      case (state)
        ST_LOAD: begin
          work <= chain;
          step <= 6'd0;
        end
        ST_STEP: begin
          work <= step_out;
          step <= 6'(step + 6'd1);
        end
        ST_ADD: begin
          if (finish) begin
            chain <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            work <= '0;
            fill <= 6'd0;
            pend <= 24'h0;
            bit_len <= 64'h0;
          end else if (after != AFT_OUT) begin
            chain <= sum;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      dig.digest_word0 <= bswap32(sum.a);
      dig.digest_word1 <= bswap32(sum.b);
      dig.digest_word2 <= bswap32(sum.c);
      dig.digest_word3 <= bswap32(sum.d);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP && step == 6'd63 |=> state == ST_ADD)
    else $error("step sequence did not end in chain add");

  assert property (@(posedge clk) disable iff (rst)
    accept && fill_sum[6] |=> state == ST_LOAD)
    else $error("full block did not start compression");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_ADD && after == AFT_OUT && dig_valid && !dig_ready |=> state == ST_ADD)
    else $error("digest overwrote a pending item");

  assert property (@(posedge clk) disable iff (rst)
    finish |=> dig_valid && fill == 6'd0)
    else $error("digest finish did not restart message");
endmodule
`default_nettype wire

// ===== rtl/core/md5_step.sv =====
// One MD5 step: round function, add chain, rotate and register shuffle.
`default_nettype none
module md5_step import md5_pkg::*; (
  input  wire abcd_t       cur,
  input  wire logic [31:0] m,
  input  wire logic [5:0]  k,
  output abcd_t            nxt
);
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot;

  always_comb begin
    case (k[5:4])
      2'd0: f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1: f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2: f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
    t = cur.a + f + m + sine_k(k);
    rot = {t, t} << rot_amount(k);
    nxt.a = cur.d;
    nxt.b = cur.b + rot[63:32];
    nxt.c = cur.b;
    nxt.d = cur.c;
  end
endmodule
`default_nettype wire
